@@ src/radix_to_base36_converter_defines.svh @@
// Assertion macros shared by the radix to base-36 converter RTL.
`ifndef RADIX_TO_BASE36_CONVERTER_DEFINES_SVH
`define RADIX_TO_BASE36_CONVERTER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RB36_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define RB36_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ src/rb36_pkg.sv @@
// Types, constants and helper functions of the radix to base-36 converter.
`default_nettype none

package rb36_pkg;

  localparam int unsigned MaxDigits = 7;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  localparam logic [7:0]  AsciiZero    = 8'd48;
  localparam logic [7:0]  LetterOffset = 8'd87;
  localparam logic [7:0]  AsciiLowerA  = 8'd97;
  localparam logic [7:0]  AsciiUpperA  = 8'd65;
  localparam logic [7:0]  AsciiUpperZ  = 8'd90;
  localparam logic [7:0]  CaseShift    = 8'd32;
  localparam logic [31:0] Div9Magic    = 32'h38E3_8E39;

  typedef enum logic [1:0] {
    MODE_BIN = 2'd0,
    MODE_OCT = 2'd1,
    MODE_DEC = 2'd2,
    MODE_HEX = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_MUL,
    ST_DIV_REM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0] char_code;
    mode_e      mode;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [6:0] digit_code;
    logic       last_digit;
  } out_req_t;

  function automatic logic [31:0] digit_value(input logic [7:0] code, input mode_e mode);
    logic [7:0] low;
    low = code;
    if (low >= AsciiUpperA && low <= AsciiUpperZ) begin
      low = low + CaseShift;
    end
    if (mode == MODE_HEX && low >= AsciiLowerA) begin
      return {24'd0, low - LetterOffset};
    end
    return {24'd0, code} - {24'd0, AsciiZero};
  endfunction

  function automatic logic [6:0] digit_ascii(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = {2'b00, d} + AsciiZero;
    end else begin
      c = {2'b00, d} + LetterOffset;
    end
    return c[6:0];
  endfunction

endpackage

`default_nettype wire

@@ src/rb36_div36.sv @@
// Shared divide-by-36 unit: registered reciprocal multiply, then quotient and remainder.
`default_nettype none

module rb36_div36 (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  output logic [26:0]      q_o,
  output logic [5:0]       r_o
);
  import rb36_pkg::*;

  logic [63:0] prod_d, prod_q;
  logic [31:0] qx36;
  logic [31:0] rem;

  assign prod_d = 64'(a_i) * 64'(Div9Magic);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor(a/9) = prod >> 33, floor(a/36) = prod >> 35
  assign q_o  = prod_q[61:35];
  assign qx36 = {q_o, 5'd0} + {3'd0, q_o, 2'd0};
  assign rem  = a_i - qx36;
  assign r_o  = rem[5:0];

endmodule

`default_nettype wire

@@ src/radix_to_base36_converter.sv @@
// Top level of the radix to base-36 converter: accumulator, digit stack and sequencer.
//
// Input channel (in_valid_i/in_ready_o/in_req_i): one ASCII digit character per
// request, most significant first, with its radix mode and a last-character flag.
// Each character is folded into a 32-bit accumulator (value*radix+digit, wrapping)
// in the cycle it is accepted, so digits stream in at one per cycle while in_ready_o is high.
// On the last character the block drops in_ready_o and converts the value with a
// shared divide-by-36 unit, one base-36 digit at a time (registered reciprocal
// multiply, then remainder); up to seven digits are pushed on a small stack.
// Output channel (out_valid_o/out_ready_i/out_req_o): the digits are then popped
// most significant first as ASCII '0'-'9','a'-'z', last_digit set on the final one.
// A zero value gives the single digit '0'.
// When the receiver stalls, the current digit holds and no new input is taken.
// After the final digit is accepted the accumulator is zero and input resumes.
// Reset (rst_ni low, asynchronous) clears the accumulator and returns to input.
`default_nettype none

module radix_to_base36_converter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rb36_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rb36_pkg::out_req_t     out_req_o
);
  import rb36_pkg::*;

  state_e            state_d, state_q;
  logic [31:0]       acc_d, acc_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic [5:0]        digit_q [MaxDigits];
  logic [31:0]       acc_scaled;
  logic [26:0]       div_q;
  logic [5:0]        div_r;
  logic              in_fire, out_fire;
  logic [CntW-1:0]   top_idx;

  rb36_div36 u_div (
    .clk_i (clk_i),
    .a_i   (acc_q),
    .q_o   (div_q),
    .r_o   (div_r)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign top_idx  = cnt_q - CntW'(1);

  always_comb begin
    case (in_req_i.mode)
      MODE_BIN: acc_scaled = {acc_q[30:0], 1'b0};
      MODE_OCT: acc_scaled = {acc_q[28:0], 3'd0};
      MODE_DEC: acc_scaled = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0};
      MODE_HEX: acc_scaled = {acc_q[27:0], 4'd0};
      default:  acc_scaled = acc_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM: begin
        if (in_fire && in_req_i.last_char) begin
          state_d = ST_DIV_MUL;
        end
      end
      ST_DIV_MUL: state_d = ST_DIV_REM;
      ST_DIV_REM: begin
        state_d = (div_q == 27'd0) ? ST_EMIT : ST_DIV_MUL;
      end
      ST_EMIT: begin
        if (out_fire && cnt_q == CntW'(1)) begin
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          acc_d = acc_scaled + digit_value(in_req_i.char_code, in_req_i.mode);
        end
      end
      ST_DIV_MUL: ;
      ST_DIV_REM: begin
        acc_d = {5'd0, div_q};
        cnt_d = cnt_q + CntW'(1);
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_fire) begin
          cnt_d = top_idx;
        end
      end
      default: ;
    endcase
  end

  assign out_req_o.digit_code = digit_ascii(digit_q[top_idx[IdxW-1:0]]);
  assign out_req_o.last_digit = (cnt_q == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_REM) begin
      digit_q[cnt_q[IdxW-1:0]] <= div_r;
    end
  end

`include "radix_to_base36_converter_defines.svh"

  `RB36_ASSERT_NEVER(a_ready_and_valid, in_ready_o && out_valid_o, "input and output active together")
  `RB36_ASSERT(a_cnt_range, cnt_q <= CntW'(MaxDigits), "digit count beyond seven")
  `RB36_ASSERT(a_last_starts_div, (in_fire && in_req_i.last_char) |=> (state_q == ST_DIV_MUL), "last character did not start conversion")
  `RB36_ASSERT(a_done_clears, (out_fire && out_req_o.last_digit) |=> (state_q == ST_ACCUM && acc_q == 32'd0), "accumulator not cleared after number")

endmodule

`default_nettype wire

@@ tb/sv/radix_to_base36_converter_tb.sv @@
// Testbench for the radix to base-36 converter: directed table plus random numbers.
module radix_to_base36_converter_tb;
  import rb36_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandChars  = 360;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0]  code;
    mode_e       mode;
    logic        last;
    logic [55:0] digits_txt;  // typed expectation, zero means use the predictor
  } dir_row_t;

  localparam int unsigned DirRows = 23;
  localparam dir_row_t DirTab [DirRows] = '{
    '{8'h30, MODE_DEC, 1'b1, 56'("0")},
    '{8'h31, MODE_BIN, 1'b1, 56'("1")},
    '{8'h41, MODE_HEX, 1'b1, 56'("a")},
    '{8'h5a, MODE_HEX, 1'b1, 56'("z")},
    '{8'h7a, MODE_HEX, 1'b1, 56'("z")},
    '{8'h46, MODE_HEX, 1'b0, 56'd0},
    '{8'h66, MODE_HEX, 1'b0, 56'd0},
    '{8'h46, MODE_HEX, 1'b0, 56'd0},
    '{8'h66, MODE_HEX, 1'b0, 56'd0},
    '{8'h46, MODE_HEX, 1'b0, 56'd0},
    '{8'h66, MODE_HEX, 1'b0, 56'd0},
    '{8'h46, MODE_HEX, 1'b0, 56'd0},
    '{8'h66, MODE_HEX, 1'b1, 56'("1z141z3")},
    '{8'h61, MODE_DEC, 1'b1, 56'("1d")},
    '{8'hff, MODE_HEX, 1'b1, 56'("4o")},
    '{8'h37, MODE_OCT, 1'b0, 56'd0},
    '{8'h37, MODE_OCT, 1'b1, 56'("1r")},
    '{8'h7f, MODE_DEC, 1'b1, 56'("27")},
    '{8'h00, MODE_BIN, 1'b1, 56'd0},
    '{8'h31, MODE_BIN, 1'b0, 56'd0},
    '{8'h47, MODE_HEX, 1'b1, 56'd0},
    '{8'hff, MODE_DEC, 1'b0, 56'd0},
    '{8'h30, MODE_DEC, 1'b1, 56'd0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_req;

  logic [31:0] acc_val;
  out_req_t    fresh_digits[$];
  out_req_t    expected_digits[$];
  int unsigned snd_idle, rcv_idle;
  int unsigned err_cnt, chars_sent, numbers_sent, digits_checked, cycle_cnt;

  radix_to_base36_converter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] digit_of_char(logic [7:0] code, mode_e mode);
    logic [7:0] lowered;
    lowered = code;
    if (mode == MODE_HEX) begin
      if (code >= AsciiUpperA && code <= AsciiUpperZ) lowered = code + CaseShift;
      if (lowered >= AsciiLowerA) return {24'd0, lowered - LetterOffset};
    end
    return {24'd0, code} - {24'd0, AsciiZero};
  endfunction

  function automatic logic [31:0] radix_of(mode_e mode);
    case (mode)
      MODE_BIN: return 32'd2;
      MODE_OCT: return 32'd8;
      MODE_DEC: return 32'd10;
      default:  return 32'd16;
    endcase
  endfunction

  // Folds one character into the running value; on the last one the base-36
  // digits land in fresh_digits, most significant first.
  function automatic void fold_char(in_req_t r);
    logic [31:0] v;
    logic [5:0]  rems[MaxDigits];
    int          n;
    out_req_t    o;
    acc_val = acc_val * radix_of(r.mode) + digit_of_char(r.char_code, r.mode);
    if (!r.last_char) return;
    v = acc_val;
    n = 0;
    do begin
      rems[n] = 6'(v % 32'd36);
      v = v / 32'd36;
      n++;
    end while (v != 0 && n < MaxDigits);
    for (int k = n - 1; k >= 0; k--) begin
      o.digit_code = (rems[k] < 6'd10) ? 7'(rems[k] + AsciiZero) : 7'(rems[k] + LetterOffset);
      o.last_digit = (k == 0);
      fresh_digits = {fresh_digits, o};
    end
    acc_val = '0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (digit %0d)", what, got, want, digits_checked);
    err_cnt++;
  endtask

  // Drives one request from a falling edge and returns at the falling edge after acceptance.
  task automatic send_char(in_req_t r, logic [55:0] digits_txt);
    out_req_t o;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req   = r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    fold_char(r);
    chars_sent++;
    if (r.last_char) numbers_sent++;
    if (digits_txt != '0) begin
      fresh_digits.delete();
      for (int i = 6; i >= 0; i--) begin
        if (digits_txt[i*8 +: 8] != 8'd0) begin
          o.digit_code = digits_txt[i*8 +: 7];
          o.last_digit = 1'b0;
          expected_digits = {expected_digits, o};
        end
      end
      expected_digits[expected_digits.size() - 1].last_digit = 1'b1;
    end else begin
      expected_digits = {expected_digits, fresh_digits};
      fresh_digits.delete();
    end
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] valid_char(mode_e mode);
    int unsigned d;
    d = $urandom_range(radix_of(mode) - 1);
    if (d < 10) return 8'(d) + AsciiZero;
    if ($urandom_range(1) == 1) return 8'(d - 10) + AsciiLowerA;
    return 8'(d - 10) + AsciiUpperA;
  endfunction

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch("unexpected digit_code", out_req.digit_code, -1);
      end else begin
        want = expected_digits.pop_front();
        if (out_req.digit_code != want.digit_code)
          report_mismatch("digit_code", out_req.digit_code, want.digit_code);
        if (out_req.last_digit != want.last_digit)
          report_mismatch("last_digit", out_req.last_digit, want.last_digit);
      end
      digits_checked++;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d digits outstanding", cycle_cnt,
             expected_digits.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_req_t r;
    mode_e   num_mode;
    int      len;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    rst_ni    = 1'b0;
    acc_val   = '0;
    snd_idle  = 17;
    rcv_idle  = 47;
    err_cnt = 0; chars_sent = 0; numbers_sent = 0; digits_checked = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      r.char_code = DirTab[i].code;
      r.mode      = DirTab[i].mode;
      r.last_char = DirTab[i].last;
      send_char(r, DirTab[i].digits_txt);
    end

    while (chars_sent < DirRows + RandChars) begin
      if (chars_sent < DirRows + RandChars / 3) begin
        snd_idle = 17; rcv_idle = 47;
      end else if (chars_sent < DirRows + 2 * RandChars / 3) begin
        snd_idle = 47; rcv_idle = 17;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      if ($urandom_range(99) < 85) begin
        // well-formed number; long ones may wrap the 32-bit value
        num_mode = mode_e'($urandom_range(3));
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 12);
        for (int k = 0; k < len; k++) begin
          r.char_code = valid_char(num_mode);
          r.mode      = num_mode;
          r.last_char = (k == len - 1);
          send_char(r, '0);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          r.char_code = 8'($urandom_range(255));
          r.mode      = mode_e'($urandom_range(3));
          r.last_char = (k == len - 1);
          send_char(r, '0);
        end
      end
    end
    in_valid = 1'b0;

    while (expected_digits.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters forming %0d numbers, checked %0d base-36 digits",
             chars_sent, numbers_sent, digits_checked);
    $display("All four radices, non-digit characters, wrap-around and mixed stalls exercised");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/rb36_pkg.sv
src/rb36_div36.sv
src/radix_to_base36_converter.sv
tb/sv/radix_to_base36_converter_tb.sv
